FILE: design/rrdf_pkg.sv
// types, constants and state codes for the duplicate request filter
// no dependencies; imported by the interfaces, the entry cell and the top level
package rrdf_pkg;

   localparam int DEPTH_DEF  = 10;
   localparam int SEQ_W      = 32;
   localparam int ADDR_W     = 32;
   localparam int IFACE_W    = 8;
   localparam int DUP_W      = 16;
   localparam logic [DUP_W-1:0] DUP_MAX = {DUP_W{1'b1}};

   typedef struct packed {
      logic [SEQ_W-1:0]   low;
      logic [SEQ_W-1:0]   high;
      logic [ADDR_W-1:0]  addr;
      logic [IFACE_W-1:0] iface;
   } entry_type;

   typedef struct packed {
      logic cmp;
      logic shift;
      logic bump;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

endpackage

FILE: design/rrdf_req_if.sv
// request channel: valid/ready handshake with the four request keys
// depends on rrdf_pkg for field widths
interface rrdf_req_if;
   import rrdf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SEQ_W-1:0]          range_low;
   logic [SEQ_W-1:0]          range_high;
   logic [ADDR_W-1:0]         turn_addr;
   logic signed [IFACE_W-1:0] turn_iface;

   modport source (output valid, range_low, range_high, turn_addr, turn_iface, input ready);
   modport sink   (input valid, range_low, range_high, turn_addr, turn_iface, output ready);
endinterface

FILE: design/rrdf_rsp_if.sv
// result channel: valid/ready handshake with new flag and duplicate counts
// depends on rrdf_pkg for field widths
interface rrdf_rsp_if;
   import rrdf_pkg::*;

   logic             valid;
   logic             ready;
   logic             is_new;
   logic [DUP_W-1:0] match_dup_count;
   logic [DUP_W-1:0] max_dup_count;

   modport source (output valid, is_new, match_dup_count, max_dup_count, input ready);
   modport sink   (input valid, is_new, match_dup_count, max_dup_count, output ready);
endinterface

FILE: design/rrdf_cell.sv
// one table slot: holds an entry, compares it with the request, shifts to its neighbor
// depends on rrdf_pkg
module rrdf_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rrdf_pkg::ctl_type       ctl,
   input  rrdf_pkg::entry_type     req_key,
   input  rrdf_pkg::entry_type     prev_key,
   input  logic [15:0]             prev_dups,
   input  logic                    prev_valid,
   output rrdf_pkg::entry_type     key_out,
   output logic [15:0]             dups_out,
   output logic                    valid_out,
   output logic                    hit,
   output logic [15:0]             hit_dups
);
   import rrdf_pkg::*;

   entry_type        key_ff;
   logic [DUP_W-1:0] dups_ff;
   logic             valid_ff;
   logic             hit_ff;
   logic             hit_in;
   logic [DUP_W-1:0] inc_ff;
   logic [DUP_W-1:0] inc_in;

   assign hit_in = valid_ff && (key_ff == req_key);
   assign inc_in = (dups_ff == DUP_MAX) ? DUP_MAX : dups_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (ctl.cmp) begin
            hit_ff <= hit_in;
         end
         if (ctl.shift) begin
            valid_ff <= prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp) begin
         inc_ff <= inc_in;
      end
      if (ctl.shift) begin
         key_ff  <= prev_key;
         dups_ff <= prev_dups;
      end else if (ctl.bump && hit_ff) begin
         dups_ff <= inc_ff;
      end
   end

   assign key_out   = key_ff;
   assign dups_out  = dups_ff;
   assign valid_out = valid_ff;
   assign hit       = hit_ff;
   assign hit_dups  = inc_ff;

endmodule

FILE: design/repair_request_duplicate_filter_unit.sv
// duplicate repair request filter: top level with sequencer and result register
// depends on rrdf_pkg, rrdf_req_if, rrdf_rsp_if and rrdf_cell
//
// req: one repair request per transfer (range low/high, turning address, interface)
// rsp: one result per request: new flag, duplicate count of the matched slot after
//      the increment (0 when new) and the peak duplicate count so far
// the table is a row of DEPTH cells, newest in cell 0; a miss shifts the row by one
// cell and drops the oldest, a hit bumps the matching cell's saturating count
// a taken request is compared in ST_CMP and committed in ST_UPD, raising rsp valid
// a request is taken only in ST_IDLE; the compare and commit steps over the
// cell row are the pacing path, each request waits for the previous commit
// a finished result sits in the output register while the next request is taken;
// if rsp is stalled, a request waiting to commit holds until the result drains
// reset (synchronous, active high) empties the table, zeroes the peak count and
// clears rsp valid
module repair_request_duplicate_filter_unit #(
   parameter int DEPTH = rrdf_pkg::DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   rrdf_req_if.sink   req,
   rrdf_rsp_if.source rsp
);
   import rrdf_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   entry_type        req_key_ff;
   entry_type        req_key_in;
   ctl_type          ctl;
   logic             take;
   logic             commit;
   logic [DUP_W-1:0] peak_ff;
   logic [DUP_W-1:0] peak_in;
   logic             rsp_valid_ff;
   logic             rsp_new_ff;
   logic [DUP_W-1:0] rsp_cnt_ff;
   logic             any_hit;
   logic [DUP_W-1:0] hit_cnt;

   entry_type        key_a   [DEPTH];
   logic [DUP_W-1:0] dups_a  [DEPTH];
   logic [DEPTH-1:0] valid_a;
   logic [DEPTH-1:0] hit_a;
   logic [DUP_W-1:0] hcnt_a  [DEPTH];

   assign req_key_in.low   = req.range_low;
   assign req_key_in.high  = req.range_high;
   assign req_key_in.addr  = req.turn_addr;
   assign req_key_in.iface = $unsigned(req.turn_iface);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_CMP;
         ST_CMP:  state_in = ST_UPD;
         ST_UPD:  if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      take      = 1'b0;
      commit    = 1'b0;
      ctl.cmp   = 1'b0;
      ctl.shift = 1'b0;
      ctl.bump  = 1'b0;
      case (state_ff)
         ST_IDLE: take = req.valid;
         ST_CMP:  ctl.cmp = 1'b1;
         ST_UPD: begin
            commit    = !rsp_valid_ff || rsp.ready;
            ctl.shift = commit && !any_hit;
            ctl.bump  = commit && any_hit;
         end
         default: take = 1'b0;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);

   // hit collect, at most one cell hits
   always_comb begin
      any_hit = 1'b0;
      hit_cnt = '0;
      for (int k = 0; k < DEPTH; k++) begin
         any_hit = any_hit | hit_a[k];
         hit_cnt = hit_cnt | (hit_a[k] ? hcnt_a[k] : '0);
      end
   end

   assign peak_in = (any_hit && (hit_cnt > peak_ff)) ? hit_cnt : peak_ff;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            rrdf_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .req_key    (req_key_ff),
               .prev_key   (req_key_ff),
               .prev_dups  ('0),
               .prev_valid (1'b1),
               .key_out    (key_a[g]),
               .dups_out   (dups_a[g]),
               .valid_out  (valid_a[g]),
               .hit        (hit_a[g]),
               .hit_dups   (hcnt_a[g])
            );
         end else begin : g_body
            rrdf_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .req_key    (req_key_ff),
               .prev_key   (key_a[g-1]),
               .prev_dups  (dups_a[g-1]),
               .prev_valid (valid_a[g-1]),
               .key_out    (key_a[g]),
               .dups_out   (dups_a[g]),
               .valid_out  (valid_a[g]),
               .hit        (hit_a[g]),
               .hit_dups   (hcnt_a[g])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            peak_ff      <= peak_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_key_ff <= req_key_in;
      end
      if (commit) begin
         rsp_new_ff <= !any_hit;
         rsp_cnt_ff <= any_hit ? hit_cnt : '0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.is_new          = rsp_new_ff;
   assign rsp.match_dup_count = rsp_cnt_ff;
   assign rsp.max_dup_count   = peak_ff;

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $onehot0(hit_a))
      else $error("more than one cell matched the request");

   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      ((valid_a >> 1) & ~valid_a) == '0)
      else $error("table slots not filled from the head");

   a_peak_rises: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> (peak_ff >= $past(peak_ff)))
      else $error("peak duplicate count decreased");

   a_dup_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_new_ff) |-> (rsp_cnt_ff != '0 && rsp_cnt_ff <= peak_ff))
      else $error("duplicate result with bad count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPD))
      else $error("result raised outside commit");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for repair_request_duplicate_filter_unit: directed, random and
// repeated request streams checked against a cycle-free table predictor
// depends on rrdf_pkg, rrdf_req_if, rrdf_rsp_if and the design top level
module testbench;
   import rrdf_pkg::*;

   localparam int TABLE_DEPTH    = DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 1140;
   localparam int BURST_ITEMS    = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int POOL_SIZE      = 8;

   typedef struct packed {
      logic             is_new;
      logic [DUP_W-1:0] dup_count;
      logic [DUP_W-1:0] peak_count;
   } filter_result_type;

   class duplicate_tracker;
      entry_type         keys[TABLE_DEPTH];
      logic [DUP_W-1:0]  dups[TABLE_DEPTH];
      bit                used[TABLE_DEPTH];
      logic [DUP_W-1:0]  peak;
      filter_result_type expected_results[$];
      int                failures;

      function new();
         foreach (used[i]) used[i] = 0;
         peak     = '0;
         failures = 0;
      endfunction

      // newest slot first; a miss shifts the table down and drops the oldest
      function void note_request(entry_type key);
         filter_result_type res;
         int                hit;
         hit = -1;
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (hit < 0 && used[i] && keys[i] == key) hit = i;
         if (hit >= 0) begin
            if (dups[hit] != DUP_MAX) dups[hit] = dups[hit] + 1'b1;
            if (dups[hit] > peak) peak = dups[hit];
            res = '{1'b0, dups[hit], peak};
         end else begin
            for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
               keys[i] = keys[i-1];
               dups[i] = dups[i-1];
               used[i] = used[i-1];
            end
            keys[0] = key;
            dups[0] = '0;
            used[0] = 1;
            res = '{1'b1, {DUP_W{1'b0}}, peak};
         end
         expected_results.push_back(res);
      endfunction

      task report(string msg);
         failures++;
         if (failures <= 20) $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_result(filter_result_type got);
         filter_result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("result with nothing pending: %p", got));
            return;
         end
         want = expected_results.pop_front();
         if (got.is_new !== want.is_new)
            report($sformatf("is_new %b, want %b", got.is_new, want.is_new));
         if (got.dup_count !== want.dup_count)
            report($sformatf("match_dup_count %0d, want %0d", got.dup_count, want.dup_count));
         if (got.peak_count !== want.peak_count)
            report($sformatf("max_dup_count %0d, want %0d", got.peak_count, want.peak_count));
      endtask

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit send_gaps    = 1;
   bit recv_stalls  = 1;
   bit hold_request = 0;
   int quiet_cycles = 0;

   duplicate_tracker tracker = new();

   rrdf_req_if req_ch();
   rrdf_rsp_if rsp_ch();

   repair_request_duplicate_filter_unit #(
      .DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_request(input entry_type key);
      req_ch.valid      <= 1'b1;
      req_ch.range_low  <= key.low;
      req_ch.range_high <= key.high;
      req_ch.turn_addr  <= key.addr;
      req_ch.turn_iface <= key.iface;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_request(key);
   endtask

   task automatic pause_request(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            tracker.check_result('{rsp_ch.is_new, rsp_ch.match_dup_count,
                                   rsp_ch.max_dup_count});
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (recv_stalls) begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 36);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      entry_type key_a;
      entry_type key;
      entry_type latest;
      entry_type pool[POOL_SIZE];
      int        pick;

      req_ch.valid      <= 1'b0;
      req_ch.range_low  <= '0;
      req_ch.range_high <= '0;
      req_ch.turn_addr  <= '0;
      req_ch.turn_iface <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extremes, repeats and near misses on each key field
      key_a = '0;
      send_request(key_a);
      send_request(key_a);
      send_request('1);
      send_request(entry_type'{32'h1234_5678, 32'h8765_4321, 32'hdead_beef, 8'h80});
      send_request(entry_type'{32'h0000_0001, 32'hffff_fffe, 32'h8000_0000, 8'h7f});
      send_request(key_a);
      key = key_a; key.low   = 32'h0000_0001; send_request(key);
      key = key_a; key.high  = 32'h8000_0000; send_request(key);
      key = key_a; key.addr  = 32'h0000_0001; send_request(key);
      key = key_a; key.iface = 8'h80;         send_request(key);
      // overflow the table so the first key is evicted
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         latest = '{$urandom, $urandom, $urandom, 8'($urandom_range(0, 255))};
         send_request(latest);
      end
      send_request(key_a);
      send_request(latest);

      foreach (pool[i]) pool[i] = '{$urandom, $urandom, $urandom, 8'($urandom_range(0, 255))};

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) hold_request = 1;
         if (n == 300) begin
            send_gaps   = 0;
            recv_stalls = 0;
         end
         if (n == 500) begin
            send_gaps   = 1;
            recv_stalls = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            key = pool[$urandom_range(0, 1)];
         end else if (pick < 70) begin
            key = pool[$urandom_range(0, POOL_SIZE - 1)];
         end else if (pick < 85) begin
            key = pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 3))
               0: key.low[$urandom_range(0, SEQ_W - 1)]     ^= 1'b1;
               1: key.high[$urandom_range(0, SEQ_W - 1)]    ^= 1'b1;
               2: key.addr[$urandom_range(0, ADDR_W - 1)]   ^= 1'b1;
               default: key.iface[$urandom_range(0, IFACE_W - 1)] ^= 1'b1;
            endcase
         end else begin
            key = '{$urandom, $urandom, $urandom, 8'($urandom_range(0, 255))};
            pool[$urandom_range(2, POOL_SIZE - 1)] = key;
         end
         if (send_gaps && $urandom_range(0, 99) < 36) pause_request($urandom_range(1, 5));
         send_request(key);
      end

      // hammer one entry back to back, then a near miss
      send_gaps   = 0;
      recv_stalls = 0;
      key = '{$urandom, $urandom, $urandom, 8'($urandom_range(0, 255))};
      for (int n = 0; n < BURST_ITEMS; n++) send_request(key);
      key.addr = ~key.addr;
      send_request(key);
      req_ch.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
